[rtl/alfd_pkg.sv]
package alfd_pkg;

  localparam int BYTE_W = 8;
  localparam int CNT_W = 10;
  localparam int IN_TDATA_W = 8;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CNT_W-1:0] CNT_MAX = 10'd1023;
  localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;
  localparam logic [BYTE_W-1:0] ASCII_NINE = 8'h39;

  localparam logic [BYTE_W-1:0] START_DELIM_RESET = 8'd2;
  localparam logic [BYTE_W-1:0] END_DELIM_RESET = 8'd3;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_START_DELIM = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_END_DELIM = 1'b1;

  typedef struct packed {
    logic [BYTE_W-1:0] start_delim;
    logic [BYTE_W-1:0] end_delim;
  } cfg_t;

  typedef struct packed {
    logic             frame_last;
    logic [CNT_W-1:0] payload_index;
    logic [BYTE_W-1:0] payload_byte;
  } result_t;

endpackage

[rtl/ascii_length_frame_deframer_top.sv]
// An accepted input item is held in the input register, and its result in the output register that drives m_axis.
// Throughput: one item per cycle unless a result waits on a stalled output; the
// header/payload next state is computed between the input register and the output register.
// Reset (rst, synchronous): clears frame state and both pipeline valid flags,
// start_delim returns to 2 and end_delim to 3. No clearing pass.
module ascii_length_frame_deframer_top #(
  parameter int LEN_DIGITS = 3
) (
  input  logic        clk,
  input  logic        rst,
  // slave side
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // master side
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] payload_byte, [17:8] payload_index, zero pad
  output logic        m_axis_tlast,   // frame_last
  // configuration
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);
  import alfd_pkg::*;

  cfg_t    cfg;
  logic    s1_valid;
  logic [BYTE_W-1:0] s1_byte;
  logic    out_valid;
  result_t out_result;
  logic    out_free;
  logic    advance;
  logic    emit;
  result_t result;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_delim <= START_DELIM_RESET;
      cfg.end_delim   <= END_DELIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_DELIM: cfg.start_delim <= cfg_wdata;
        REG_END_DELIM:   cfg.end_delim   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  alfd_parser #(
    .LEN_DIGITS(LEN_DIGITS)
  ) u_parser (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .rx_byte(s1_byte),
    .cfg    (cfg),
    .emit   (emit),
    .result (result)
  );

  // items with no result pass even while the output is stalled
  assign out_free      = !out_valid || m_axis_tready;
  assign advance       = s1_valid && (!emit || out_free);
  assign s_axis_tready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      s1_byte <= s_axis_tdata[BYTE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= advance && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_result <= result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {
    (OUT_TDATA_W - CNT_W - BYTE_W)'(0), out_result.payload_index, out_result.payload_byte
  };
  assign m_axis_tlast  = out_result.frame_last;

  a_reset_clears: assert property (@(posedge clk) rst |=> !s1_valid && !out_valid)
    else $error("pipeline not cleared by reset");

  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1_byte))
    else $error("stalled input register lost its item");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> s1_valid)
    else $error("input stalled with empty input register");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !m_axis_tready |=> out_valid)
    else $error("pending result dropped");

endmodule

[rtl/alfd_parser.sv]
module alfd_parser #(
  parameter int LEN_DIGITS = 3
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  logic [7:0]             rx_byte,
  input  alfd_pkg::cfg_t         cfg,
  output logic                   emit,
  output alfd_pkg::result_t      result
);
  import alfd_pkg::*;

  localparam int DCW = $clog2(LEN_DIGITS + 1);
  localparam logic [DCW-1:0] DIGIT_LIMIT = DCW'(LEN_DIGITS);
  localparam int PROD_W = CNT_W + 4;

  logic             in_header, in_header_next;
  logic [DCW-1:0]   digit_count, digit_count_next;
  logic             digits_stopped, digits_stopped_next;
  logic [CNT_W-1:0] length_accum, length_accum_next;
  logic [CNT_W-1:0] frame_length, frame_length_next;
  logic [CNT_W-1:0] byte_count, byte_count_next;

  logic              hit_start;
  logic              hit_end;
  logic              is_digit;
  logic [3:0]        digit_val;
  logic [PROD_W-1:0] acc_wide;
  logic [PROD_W-1:0] acc_sum;
  logic [CNT_W-1:0]  acc_sat;
  logic [CNT_W-1:0]  byte_count_inc;

  assign hit_start = (rx_byte == cfg.start_delim);
  assign hit_end   = !hit_start && (rx_byte == cfg.end_delim);
  assign is_digit  = (rx_byte >= ASCII_ZERO) && (rx_byte <= ASCII_NINE);
  // '0'..'9' are 0x30..0x39, so the low nibble is the digit
  assign digit_val = rx_byte[3:0];

  // accum * 10 + digit, saturating
  assign acc_wide = {4'b0, length_accum};
  assign acc_sum  = (acc_wide << 3) + (acc_wide << 1) + PROD_W'(digit_val);
  assign acc_sat  = (acc_sum > PROD_W'(CNT_MAX)) ? CNT_MAX : acc_sum[CNT_W-1:0];

  assign byte_count_inc = byte_count + 1'b1;

  assign emit = !hit_start && !hit_end && !in_header && (byte_count < frame_length);

  assign result.payload_byte  = rx_byte;
  assign result.payload_index = byte_count;
  assign result.frame_last    = (byte_count_inc == frame_length);

  always_comb begin
    in_header_next      = in_header;
    digit_count_next    = digit_count;
    digits_stopped_next = digits_stopped;
    length_accum_next   = length_accum;
    frame_length_next   = frame_length;
    byte_count_next     = byte_count;
    if (hit_start) begin
      in_header_next      = 1'b1;
      digit_count_next    = '0;
      digits_stopped_next = 1'b0;
      length_accum_next   = '0;
    end else if (hit_end) begin
      in_header_next    = 1'b0;
      digit_count_next  = '0;
      frame_length_next = length_accum;
      byte_count_next   = '0;
    end else if (in_header) begin
      if (!digits_stopped && (digit_count < DIGIT_LIMIT)) begin
        if (!is_digit) begin
          digits_stopped_next = 1'b1;
        end else begin
          length_accum_next = acc_sat;
          digit_count_next  = digit_count + 1'b1;
        end
      end
    end else if (emit) begin
      byte_count_next = byte_count_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_header      <= 1'b0;
      digit_count    <= '0;
      digits_stopped <= 1'b0;
      length_accum   <= '0;
      frame_length   <= '0;
      byte_count     <= '0;
    end else if (step) begin
      in_header      <= in_header_next;
      digit_count    <= digit_count_next;
      digits_stopped <= digits_stopped_next;
      length_accum   <= length_accum_next;
      frame_length   <= frame_length_next;
      byte_count     <= byte_count_next;
    end
  end

endmodule
